@@ hdl/okrl_pkg.sv @@
// Shared types and constants for the ordered keyed record list.
// Used by okrl_cell and ordered_keyed_record_list; depends on nothing.
`default_nettype none
package okrl_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int POS_W   = 4;
  // wide enough for count, cell index and position alike
  localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;
  localparam int TOTAL_W = 5;
  localparam int FPOS_W  = 4;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } fsm_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] num;
  } rec_t;

  // per-cell load controls
  typedef struct packed {
    logic wr_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/ordered_keyed_record_list.sv @@
// Every item passes through accept, update and compare in the cell
// chain, then first-match select; done pulses in the cycle after that and
// busy drops in that same cycle, so the next item is taken only once busy has dropped.
// The receiver cannot stall; done is a one-cycle strobe.
// Synchronous reset empties the list; record contents are not cleared.
`default_nettype none
module ordered_keyed_record_list (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] street_number,
  input  wire logic [3:0]  position,
  output logic             done,
  output logic [2:0]       status,
  output logic [3:0]       found_position,
  output logic signed [31:0] found_key,
  output logic signed [31:0] found_street_number,
  output logic [4:0]       entry_total
);
  import okrl_pkg::*;

  fsm_t state, state_next;

  logic [1:0]         op_q;
  logic [POS_W-1:0]   pos_q;
  rec_t               in_rec;
  logic [COUNT_W-1:0] count;
  logic [DEPTH-1:0]   match_q;
  status_t            exec_status;

  rec_t               cell_rec   [DEPTH];
  rec_t               cell_next  [DEPTH];
  cell_ctrl_t         cell_ctrl  [DEPTH];
  logic [DEPTH-1:0]   cell_match;
  logic [DEPTH-1:0]   valid_mask;

  logic [CMP_W-1:0]   count_ext;
  logic [CMP_W-1:0]   pos_ext;
  logic               is_exec;
  logic               room;
  logic               pos_ok;

  logic [IDX_W-1:0]   hit_idx;
  logic               hit;

  assign count_ext = CMP_W'(count);
  assign pos_ext   = CMP_W'(pos_q);
  assign is_exec   = (state == S_EXEC);
  assign room      = (count_ext < CMP_W'(DEPTH));
  assign pos_ok    = (pos_ext < count_ext);
  assign busy      = (state != S_IDLE);

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      assign cell_next[i] = '0;
    end else begin : g_mid
      assign cell_next[i] = cell_rec[i + 1];
    end
    assign valid_mask[i]      = (CMP_W'(i) < count_ext);
    assign cell_ctrl[i].wr_en = is_exec && (op_q == OP_APPEND) && room &&
                                (count_ext == CMP_W'(i));
    assign cell_ctrl[i].shift_en = is_exec && (op_q == OP_REMOVE) && pos_ok &&
                                   (CMP_W'(i) >= pos_ext);
    okrl_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .wr_rec     (in_rec),
      .next_rec   (cell_next[i]),
      .search_key (in_rec.key),
      .rec        (cell_rec[i]),
      .match      (cell_match[i])
    );
  end

  // first match: scan from the tail so the lowest index wins
  always_comb begin
    hit_idx = '0;
    hit     = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IDX_W'(i);
        hit     = 1'b1;
      end
    end
  end

  always_comb begin
    exec_status = ST_OK;
    case (op_q)
      OP_APPEND: exec_status = room ? ST_OK : ST_FULL;
      OP_REMOVE: exec_status = pos_ok ? ST_OK : ST_RANGE;
      default:   exec_status = ST_OK;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_EXEC;
      S_EXEC:   state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_REPORT);
      if (is_exec) begin
        if ((op_q == OP_APPEND) && room) begin
          count <= count + COUNT_W'(1);
        end else if ((op_q == OP_REMOVE) && pos_ok) begin
          count <= count - COUNT_W'(1);
        end
      end
    end
  end

  // payload: latch the item, the compare vector and the result
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q       <= op;
      pos_q      <= position;
      in_rec.key <= key;
      in_rec.num <= street_number;
    end
    if (is_exec) begin
      match_q <= cell_match & valid_mask;
      status  <= exec_status;
    end
    if (state == S_REPORT) begin
      found_position      <= '0;
      found_key           <= '0;
      found_street_number <= '0;
      entry_total         <= TOTAL_W'(count);
      if (op_q == OP_FIND) begin
        if (count == '0) begin
          status <= ST_EMPTY;
        end else if (hit) begin
          status              <= ST_OK;
          found_position      <= FPOS_W'(hit_idx);
          found_key           <= cell_rec[hit_idx].key;
          found_street_number <= cell_rec[hit_idx].num;
        end else begin
          status <= ST_NOT_FOUND;
        end
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_ext <= CMP_W'(DEPTH)) else $error("entry count over capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item accepted but not busy");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count_ext == CMP_W'(DEPTH)))
    else $error("full reported below capacity");

  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (is_exec && op_q == OP_APPEND && room) |=> (count == $past(count) + COUNT_W'(1)))
    else $error("append did not grow the list");

endmodule
`default_nettype wire

@@ hdl/okrl_cell.sv @@
// One storage cell of the record chain: holds one record, takes a new one
// at the tail or its upper neighbor's on removal. Depends on okrl_pkg.
`default_nettype none
module okrl_cell (
  input  wire logic              clk,
  input  wire okrl_pkg::cell_ctrl_t ctrl,
  input  wire okrl_pkg::rec_t    wr_rec,
  input  wire okrl_pkg::rec_t    next_rec,
  input  wire logic signed [31:0] search_key,
  output okrl_pkg::rec_t         rec,
  output logic                   match
);
  import okrl_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      rec <= wr_rec;
    end else if (ctrl.shift_en) begin
      rec <= next_rec;
    end
  end

  assign match = (rec.key == search_key);

endmodule
`default_nettype wire

@@ tb/ordered_keyed_record_list_tb.sv @@
// Self-checking testbench for ordered_keyed_record_list: a directed table,
// then random append/find/remove traffic checked against a local list model.
// Depends on okrl_pkg and the ordered_keyed_record_list RTL only.
module ordered_keyed_record_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import okrl_pkg::*;

  localparam logic [1:0]         OP_UNUSED   = 2'd3;
  localparam logic signed [31:0] KEY_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX     = 32'sh7fff_ffff;
  localparam int                 RAND_ITEMS  = 900;
  localparam int                 CYCLE_LIMIT = 200000;

  typedef struct {
    status_t            status;
    logic [3:0]         fpos;
    logic signed [31:0] fkey;
    logic signed [31:0] fnum;
    logic [4:0]         total;
  } list_result_t;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] num;
    logic [3:0]         pos;
    bit                 typed;
    status_t            status;
    logic [3:0]         fpos;
    logic signed [31:0] fkey;
    logic signed [31:0] fnum;
    logic [4:0]         total;
  } directed_row_t;

  localparam int N_ROWS = 19;
  directed_row_t directed_rows [N_ROWS] = '{
    '{OP_FIND,   32'sd0,  32'sd0,  4'd0,  1'b1, ST_EMPTY,     4'd0, 32'sd0,  32'sd0,  5'd0},
    '{OP_REMOVE, 32'sd0,  32'sd0,  4'd0,  1'b1, ST_RANGE,     4'd0, 32'sd0,  32'sd0,  5'd0},
    '{OP_UNUSED, KEY_MAX, KEY_MAX, 4'd15, 1'b1, ST_OK,        4'd0, 32'sd0,  32'sd0,  5'd0},
    '{OP_APPEND, KEY_MIN, KEY_MAX, 4'd0,  1'b1, ST_OK,        4'd0, 32'sd0,  32'sd0,  5'd1},
    '{OP_APPEND, KEY_MAX, KEY_MIN, 4'd0,  1'b1, ST_OK,        4'd0, 32'sd0,  32'sd0,  5'd2},
    '{OP_APPEND, -32'sd1, 32'sd0,  4'd15, 1'b1, ST_OK,        4'd0, 32'sd0,  32'sd0,  5'd3},
    '{OP_APPEND, 32'sd0,  -32'sd1, 4'd0,  1'b1, ST_OK,        4'd0, 32'sd0,  32'sd0,  5'd4},
    '{OP_FIND,   KEY_MAX, 32'sd0,  4'd0,  1'b1, ST_OK,        4'd1, KEY_MAX, KEY_MIN, 5'd4},
    '{OP_FIND,   KEY_MIN, 32'sd0,  4'd0,  1'b1, ST_OK,        4'd0, KEY_MIN, KEY_MAX, 5'd4},
    '{OP_FIND,   32'sd1,  32'sd0,  4'd0,  1'b1, ST_NOT_FOUND, 4'd0, 32'sd0,  32'sd0,  5'd4},
    '{OP_APPEND, KEY_MAX, 32'sd7,  4'd0,  1'b1, ST_OK,        4'd0, 32'sd0,  32'sd0,  5'd5},
    '{OP_FIND,   KEY_MAX, 32'sd0,  4'd0,  1'b1, ST_OK,        4'd1, KEY_MAX, KEY_MIN, 5'd5},
    '{OP_REMOVE, 32'sd0,  32'sd0,  4'd5,  1'b1, ST_RANGE,     4'd0, 32'sd0,  32'sd0,  5'd5},
    '{OP_REMOVE, 32'sd0,  32'sd0,  4'd15, 1'b1, ST_RANGE,     4'd0, 32'sd0,  32'sd0,  5'd5},
    '{OP_REMOVE, 32'sd0,  32'sd0,  4'd1,  1'b1, ST_OK,        4'd0, 32'sd0,  32'sd0,  5'd4},
    '{OP_FIND,   KEY_MAX, 32'sd0,  4'd0,  1'b1, ST_OK,        4'd3, KEY_MAX, 32'sd7,  5'd4},
    '{OP_REMOVE, 32'sd0,  32'sd0,  4'd3,  1'b0, ST_OK,        4'd0, 32'sd0,  32'sd0,  5'd0},
    '{OP_REMOVE, 32'sd0,  32'sd0,  4'd0,  1'b0, ST_OK,        4'd0, 32'sd0,  32'sd0,  5'd0},
    '{OP_FIND,   32'sd0,  32'sd0,  4'd0,  1'b0, ST_OK,        4'd0, 32'sd0,  32'sd0,  5'd0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [1:0]          op = OP_APPEND;
  logic signed [31:0]  key = '0;
  logic signed [31:0]  street_number = '0;
  logic [3:0]          position = '0;
  logic                busy;
  logic                done;
  logic [2:0]          status;
  logic [3:0]          found_position;
  logic signed [31:0]  found_key;
  logic signed [31:0]  found_street_number;
  logic [4:0]          entry_total;

  // local copy of the list
  logic signed [31:0]  list_keys [DEPTH];
  logic signed [31:0]  list_numbers [DEPTH];
  int                  list_count = 0;

  list_result_t        pending_results [$];
  list_result_t        no_typed;
  int                  errors = 0;
  int                  results_checked = 0;
  int                  op_seen [4] = '{0, 0, 0, 0};
  int                  status_seen [5] = '{0, 0, 0, 0, 0};
  int                  cycle_count = 0;
  bit                  no_idle = 1'b0;

  ordered_keyed_record_list dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .op                  (op),
    .key                 (key),
    .street_number       (street_number),
    .position            (position),
    .done                (done),
    .status              (status),
    .found_position      (found_position),
    .found_key           (found_key),
    .found_street_number (found_street_number),
    .entry_total         (entry_total)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
      $display("ordered_keyed_record_list regression: fail");
      $finish;
    end
  end

  task automatic update_list(input logic [1:0] cmd, input logic signed [31:0] k,
                             input logic signed [31:0] n, input logic [3:0] p,
                             output list_result_t r);
    int  i;
    bit  hit;
    r.status = ST_OK;
    r.fpos   = '0;
    r.fkey   = '0;
    r.fnum   = '0;
    hit      = 1'b0;
    case (cmd)
      OP_APPEND: begin
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_keys[list_count]    = k;
          list_numbers[list_count] = n;
          list_count++;
        end
      end
      OP_FIND: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 0; i < list_count && !hit; i++) begin
            if (list_keys[i] == k) begin
              hit    = 1'b1;
              r.fpos = i[3:0];
              r.fkey = list_keys[i];
              r.fnum = list_numbers[i];
            end
          end
          if (!hit) r.status = ST_NOT_FOUND;
        end
      end
      OP_REMOVE: begin
        if (p >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          // close the gap, keep the order
          for (i = p; i + 1 < list_count; i++) begin
            list_keys[i]    = list_keys[i + 1];
            list_numbers[i] = list_numbers[i + 1];
          end
          list_count--;
        end
      end
      default: ;
    endcase
    r.total = list_count[4:0];
  endtask

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 50) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 11))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return 32'sh5555_5555;
      6: return 32'shaaaa_aaaa;
      7: return 32'sd100;
      default: return $urandom;
    endcase
  endfunction

  // present one item and hold it until accepted; start stays high into a
  // back-to-back item
  task automatic issue(input logic [1:0] cmd, input logic signed [31:0] k,
                       input logic signed [31:0] n, input logic [3:0] p,
                       input bit typed, input list_result_t typed_res);
    int           gap;
    list_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    op            <= cmd;
    key           <= k;
    street_number <= n;
    position      <= p;
    do @(posedge clk); while (busy !== 1'b0);
    update_list(cmd, k, n, p, r);
    if (typed) r = typed_res;
    pending_results.push_back(r);
    op_seen[cmd]++;
    status_seen[r.status]++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d total %0d",
                 $time, status, entry_total);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("found_position", 32'(want.fpos), 32'(found_position));
        check_field("found_key", want.fkey, found_key);
        check_field("found_street_number", want.fnum, found_street_number);
        check_field("entry_total", 32'(want.total), 32'(entry_total));
        results_checked++;
      end
    end
  end

  initial begin
    int                 i;
    int                 sel;
    int                 app_top;
    int                 find_top;
    bit                 grow;
    logic [1:0]         cmd;
    logic signed [31:0] k;
    logic signed [31:0] n;
    logic [3:0]         p;
    list_result_t       row_res;

    no_typed.status = ST_OK;
    no_typed.fpos   = '0;
    no_typed.fkey   = '0;
    no_typed.fnum   = '0;
    no_typed.total  = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_ROWS; i++) begin
      row_res.status = directed_rows[i].status;
      row_res.fpos   = directed_rows[i].fpos;
      row_res.fkey   = directed_rows[i].fkey;
      row_res.fnum   = directed_rows[i].fnum;
      row_res.total  = directed_rows[i].total;
      issue(directed_rows[i].op, directed_rows[i].key, directed_rows[i].num,
            directed_rows[i].pos, directed_rows[i].typed, row_res);
    end

    // fill to capacity, then hit the full, last-entry and range cases
    while (list_count < DEPTH)
      issue(OP_APPEND, $urandom, $urandom, 4'($urandom_range(0, 15)), 1'b0, no_typed);
    issue(OP_APPEND, $urandom, $urandom, 4'd0, 1'b0, no_typed);
    issue(OP_FIND, list_keys[DEPTH - 1], 32'sd0, 4'd0, 1'b0, no_typed);
    issue(OP_REMOVE, 32'sd0, 32'sd0, 4'd15, 1'b0, no_typed);
    issue(OP_REMOVE, 32'sd0, 32'sd0, 4'd15, 1'b0, no_typed);

    grow = 1'b0;
    for (i = 0; i < RAND_ITEMS; i++) begin
      // alternate growing and shrinking phases so the list sweeps its range
      if (i % 75 == 0) begin
        grow    = ~grow;
        no_idle = ($urandom_range(0, 3) == 0);
      end
      app_top  = grow ? 52 : 27;
      find_top = grow ? 80 : 70;
      sel      = $urandom_range(0, 99);
      if (sel < 2)             cmd = OP_UNUSED;
      else if (sel < app_top)  cmd = OP_APPEND;
      else if (sel < find_top) cmd = OP_FIND;
      else                     cmd = OP_REMOVE;

      if (cmd == OP_FIND && list_count > 0 && $urandom_range(0, 9) < 6)
        k = list_keys[$urandom_range(0, list_count - 1)];
      else if (cmd == OP_FIND || cmd == OP_APPEND)
        k = pick_key();
      else
        k = $urandom;

      sel = $urandom_range(0, 19);
      if (sel == 0)      n = KEY_MIN;
      else if (sel == 1) n = KEY_MAX;
      else               n = $urandom;

      if (cmd == OP_REMOVE && list_count > 0 && $urandom_range(0, 9) < 8)
        p = 4'($urandom_range(0, list_count - 1));
      else
        p = 4'($urandom_range(0, 15));

      issue(cmd, k, n, p, 1'b0, no_typed);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("items: append %0d, find %0d, remove %0d, unused op %0d; %0d results compared",
             op_seen[OP_APPEND], op_seen[OP_FIND], op_seen[OP_REMOVE], op_seen[OP_UNUSED],
             results_checked);
    $display("outcomes: ok %0d, not found %0d, empty %0d, full %0d, out of range %0d",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_EMPTY],
             status_seen[ST_FULL], status_seen[ST_RANGE]);
    if (errors == 0) begin
      $display("ordered_keyed_record_list regression: pass");
    end else begin
      $display("ordered_keyed_record_list regression: fail");
    end
    $finish;
  end

endmodule

@@ ordered_keyed_record_list.f @@
hdl/okrl_pkg.sv
hdl/okrl_cell.sv
hdl/ordered_keyed_record_list.sv
tb/ordered_keyed_record_list_tb.sv
